// File: design/tspr_pkg.sv
// Shared types and constants for the three-phase start-up ramp.
// Holds the configuration and sequencer state structs and register indexes.
// No dependencies.
`default_nettype none

package tspr_pkg;

  localparam int DelayW   = 16;
  localparam int StageW   = 8;
  localparam int PeriodW  = 8;
  localparam int CfgIdxW  = 4;
  localparam int CfgDataW = 16;

  // Configuration register indexes
  localparam logic [CfgIdxW-1:0] RegInitialDelay   = 4'd0;
  localparam logic [CfgIdxW-1:0] RegCoarseThresh   = 4'd1;
  localparam logic [CfgIdxW-1:0] RegCoarseDec      = 4'd2;
  localparam logic [CfgIdxW-1:0] RegFineThresh     = 4'd3;
  localparam logic [CfgIdxW-1:0] RegFineDec        = 4'd4;
  localparam logic [CfgIdxW-1:0] RegEarlyPeriod    = 4'd5;
  localparam logic [CfgIdxW-1:0] RegLatePeriod     = 4'd6;
  localparam logic [CfgIdxW-1:0] RegEarlyStages    = 4'd7;

  // Reset values of the configuration registers
  localparam logic [DelayW-1:0]  RstInitialDelay = 16'd20000;
  localparam logic [DelayW-1:0]  RstCoarseThresh = 16'd12000;
  localparam logic [DelayW-1:0]  RstCoarseDec    = 16'd1000;
  localparam logic [DelayW-1:0]  RstFineThresh   = 16'd4000;
  localparam logic [DelayW-1:0]  RstFineDec      = 16'd500;
  localparam logic [PeriodW-1:0] RstEarlyPeriod  = 8'd20;
  localparam logic [PeriodW-1:0] RstLatePeriod   = 8'd25;
  localparam logic [StageW-1:0]  RstEarlyStages  = 8'd8;

  // Phase indexes and coil patterns
  localparam logic [1:0] PhaseCoil0 = 2'd0;
  localparam logic [1:0] PhaseCoil1 = 2'd1;
  localparam logic [1:0] PhaseCoil2 = 2'd2;
  localparam logic [2:0] DriveOff   = 3'b000;
  localparam logic [2:0] DriveCoil0 = 3'b001;
  localparam logic [2:0] DriveCoil1 = 3'b010;
  localparam logic [2:0] DriveCoil2 = 3'b100;

  localparam logic [StageW-1:0] StageMax = 8'd255;

  typedef struct packed {
    logic [DelayW-1:0]  coarse_threshold;
    logic [DelayW-1:0]  coarse_decrement;
    logic [DelayW-1:0]  fine_threshold;
    logic [DelayW-1:0]  fine_decrement;
    logic [PeriodW-1:0] early_period;
    logic [PeriodW-1:0] late_period;
    logic [StageW-1:0]  early_stages;
  } cfg_t;

  typedef struct packed {
    logic [1:0]         phase_index;
    logic [2:0]         drive_lines;
    logic [DelayW-1:0]  countdown;
    logic [DelayW-1:0]  phase_delay;
    logic [StageW-1:0]  stage_count;
    logic [PeriodW-1:0] early_residue;
    logic [PeriodW-1:0] late_residue;
  } seq_state_t;

endpackage

`default_nettype wire

// File: design/three_phase_startup_ramp.sv
// Three-phase start-up ramp: one tick transfer in, one result transfer out.
// Path: the input register holds the tick, then the result register holds its result.
// Throughput: one tick per cycle while out_stall is low; the sequencer state
// updates as the input register hands its tick to the result register.
// Reset (rst_n low, synchronous): config returns to defaults, coils off,
// countdown and stage zero, phase delay at the default initial delay.
`default_nettype none

module three_phase_startup_ramp
  import tspr_pkg::*;
(
  input  wire logic                clk,
  input  wire logic                rst_n,
  // configuration write port
  input  wire logic                cfg_we,
  input  wire logic [CfgIdxW-1:0]  cfg_index,
  input  wire logic [CfgDataW-1:0] cfg_data,
  // tick channel
  input  wire logic                in_valid,
  output logic                     in_stall,
  input  wire logic                in_enable,
  // result channel
  output logic                     out_valid,
  input  wire logic                out_stall,
  output logic [2:0]               out_drive,
  output logic [StageW-1:0]        out_stage,
  output logic [DelayW-1:0]        out_delay_us,
  output logic                     out_stage_changed
);

  cfg_t              cfg_r;
  seq_state_t        st_r;
  seq_state_t        st_nxt;
  logic              in_v_r;
  logic              in_en_r;
  logic              out_v_r;
  logic [2:0]        drive_r;
  logic [StageW-1:0] stage_r;
  logic [DelayW-1:0] delay_r;
  logic              changed_r;
  logic              changed_nxt;
  logic              advance;
  logic              in_load;

  // Move the held tick on when the result register is free or draining
  assign advance  = in_v_r && (!out_v_r || !out_stall);
  assign in_stall = in_v_r && !advance;
  assign in_load  = in_valid && !in_stall;

  tspr_step u_step (
    .enable        (in_en_r),
    .cfg           (cfg_r),
    .cur           (st_r),
    .nxt           (st_nxt),
    .stage_changed (changed_nxt)
  );

  // Control state, config and sequencer state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.coarse_threshold <= RstCoarseThresh;
      cfg_r.coarse_decrement <= RstCoarseDec;
      cfg_r.fine_threshold   <= RstFineThresh;
      cfg_r.fine_decrement   <= RstFineDec;
      cfg_r.early_period     <= RstEarlyPeriod;
      cfg_r.late_period      <= RstLatePeriod;
      cfg_r.early_stages     <= RstEarlyStages;
      st_r.phase_index       <= PhaseCoil0;
      st_r.drive_lines       <= DriveOff;
      st_r.countdown         <= '0;
      st_r.phase_delay       <= RstInitialDelay;
      st_r.stage_count       <= '0;
      st_r.early_residue     <= '0;
      st_r.late_residue      <= '0;
      in_v_r                 <= 1'b0;
      out_v_r                <= 1'b0;
    end else begin
      if (advance) begin
        st_r <= st_nxt;
      end
      // The user sends config writes only while idle; the block does not enforce it.
      if (cfg_we) begin
        case (cfg_index)
          RegInitialDelay: begin
            st_r.phase_delay <= (cfg_data == '0) ? DelayW'(1) : cfg_data;
          end
          RegCoarseThresh: cfg_r.coarse_threshold <= cfg_data;
          RegCoarseDec:    cfg_r.coarse_decrement <= cfg_data;
          RegFineThresh:   cfg_r.fine_threshold   <= cfg_data;
          RegFineDec:      cfg_r.fine_decrement   <= cfg_data;
          RegEarlyPeriod:  cfg_r.early_period     <= cfg_data[PeriodW-1:0];
          RegLatePeriod:   cfg_r.late_period      <= cfg_data[PeriodW-1:0];
          RegEarlyStages:  cfg_r.early_stages     <= cfg_data[StageW-1:0];
          default: ;
        endcase
      end
      if (in_load) begin
        in_v_r <= 1'b1;
      end else if (advance) begin
        in_v_r <= 1'b0;
      end
      if (advance) begin
        out_v_r <= 1'b1;
      end else if (!out_stall) begin
        out_v_r <= 1'b0;
      end
    end
  end

  // Payload registers: hold the tick and the result
  always_ff @(posedge clk) begin
    if (in_load) begin
      in_en_r <= in_enable;
    end
    if (advance) begin
      drive_r   <= st_nxt.drive_lines;
      stage_r   <= st_nxt.stage_count;
      delay_r   <= st_nxt.phase_delay;
      changed_r <= changed_nxt;
    end
  end

  assign out_valid         = out_v_r;
  assign out_drive         = drive_r;
  assign out_stage         = stage_r;
  assign out_delay_us      = delay_r;
  assign out_stage_changed = changed_r;

  // Coil lines are never driven two at a time
  a_drive_onehot: assert property (@(posedge clk) disable iff (!rst_n)
    $onehot0(st_r.drive_lines))
    else $error("more than one coil driven");

  // Phase delay never reaches zero
  a_delay_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    st_r.phase_delay != '0)
    else $error("phase delay is zero");

  // A stage advance only happens at the end of an electrical cycle
  a_change_on_coil2: assert property (@(posedge clk) disable iff (!rst_n)
    (out_v_r && changed_r) |-> (drive_r == DriveCoil2))
    else $error("stage change away from coil 2");

  // A blocked tick stays in the input register
  a_tick_held: assert property (@(posedge clk) disable iff (!rst_n)
    (in_v_r && out_v_r && out_stall) |=> in_v_r)
    else $error("held tick dropped");

endmodule

`default_nettype wire

// File: design/tspr_step.sv
// Next-state logic of the start-up sequencer for one microsecond tick.
// Purely combinational; uses tspr_pkg for the state and config structs.
`default_nettype none

module tspr_step
  import tspr_pkg::*;
(
  input  wire logic       enable,
  input  wire cfg_t       cfg,
  input  wire seq_state_t cur,
  output seq_state_t      nxt,
  output logic            stage_changed
);

  logic [PeriodW:0]  early_inc;
  logic [PeriodW:0]  late_inc;
  logic [PeriodW:0]  early_lim;
  logic [PeriodW:0]  late_lim;
  logic              early_wrap;
  logic              late_wrap;
  logic              check_due;
  logic              coarse_hit;
  logic              fine_hit;
  logic [DelayW-1:0] coarse_val;
  logic [DelayW-1:0] fine_val;
  logic [DelayW-1:0] delay_eff;

  // Residue counters: a period of zero acts as 256
  always_comb begin
    early_inc  = {1'b0, cur.early_residue} + 1'b1;
    late_inc   = {1'b0, cur.late_residue} + 1'b1;
    early_lim  = (cfg.early_period == '0) ? {1'b1, {PeriodW{1'b0}}}
                                          : {1'b0, cfg.early_period};
    late_lim   = (cfg.late_period == '0) ? {1'b1, {PeriodW{1'b0}}}
                                         : {1'b0, cfg.late_period};
    early_wrap = (early_inc >= early_lim);
    late_wrap  = (late_inc >= late_lim);
    check_due  = (cur.stage_count < cfg.early_stages) ? early_wrap : late_wrap;
  end

  // Floored decrements for the coarse and fine regions
  always_comb begin
    coarse_hit = (cur.phase_delay > cfg.coarse_threshold);
    fine_hit   = (cur.phase_delay > cfg.fine_threshold);
    coarse_val = (cfg.coarse_decrement >= cur.phase_delay) ? DelayW'(1)
                 : cur.phase_delay - cfg.coarse_decrement;
    fine_val   = (cfg.fine_decrement >= cur.phase_delay) ? DelayW'(1)
                 : cur.phase_delay - cfg.fine_decrement;
  end

  // Advance the phase, run the end-of-cycle stage check, reload the countdown
  always_comb begin
    nxt           = cur;
    stage_changed = 1'b0;
    delay_eff     = cur.phase_delay;
    if (enable) begin
      if (cur.countdown == '0) begin
        case (cur.phase_index)
          PhaseCoil1: begin
            nxt.drive_lines = DriveCoil1;
            nxt.phase_index = PhaseCoil2;
          end
          PhaseCoil2: begin
            nxt.drive_lines   = DriveCoil2;
            nxt.phase_index   = PhaseCoil0;
            nxt.early_residue = early_wrap ? '0 : early_inc[PeriodW-1:0];
            nxt.late_residue  = late_wrap ? '0 : late_inc[PeriodW-1:0];
            if (check_due && (coarse_hit || fine_hit)) begin
              delay_eff     = coarse_hit ? coarse_val : fine_val;
              stage_changed = 1'b1;
              if (cur.stage_count != StageMax) begin
                nxt.stage_count = cur.stage_count + 1'b1;
              end
            end
          end
          default: begin
            nxt.drive_lines = DriveCoil0;
            nxt.phase_index = PhaseCoil1;
          end
        endcase
        if (delay_eff == '0) begin
          delay_eff = DelayW'(1);
        end
        nxt.phase_delay = delay_eff;
        nxt.countdown   = delay_eff - 1'b1;
      end else begin
        nxt.countdown = cur.countdown - 1'b1;
      end
    end
  end

endmodule

`default_nettype wire

// File: sim/three_phase_startup_ramp_tb.sv
// Self-checking testbench for three_phase_startup_ramp: directed table, then random ramps.
// Predicts each result with its own model of the sequencer, or a typed row's table value.
// Depends on tspr_pkg and the three_phase_startup_ramp RTL.
module three_phase_startup_ramp_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import tspr_pkg::*;

  localparam int CycleLimit  = 200000;
  localparam int RandomTicks = 1050;
  localparam int SatTicks    = 850;
  localparam int LongHold    = 40;
  localparam logic [CfgIdxW-1:0] RegSpare = 4'd9;

  typedef struct packed {
    logic [2:0]        drive;
    logic [StageW-1:0] stage;
    logic [DelayW-1:0] delay_us;
    logic              changed;
  } ramp_out_t;

  typedef enum logic {RowTick, RowWrite} row_kind_t;

  typedef struct {
    row_kind_t           kind;
    logic [CfgIdxW-1:0]  idx;
    logic [CfgDataW-1:0] data;
    logic                en;
    bit                  typed;
    ramp_out_t           want;
  } plan_row_t;

  logic clk;
  logic rst_n;
  logic cfg_we;
  logic [CfgIdxW-1:0] cfg_index;
  logic [CfgDataW-1:0] cfg_data;
  logic in_valid, in_stall, in_enable;
  logic out_valid, out_stall;
  logic [2:0] out_drive;
  logic [StageW-1:0] out_stage;
  logic [DelayW-1:0] out_delay_us;
  logic out_stage_changed;

  // Own copy of the sequencer
  cfg_t              ramp_cfg;
  seq_state_t        ramp_st;

  ramp_out_t ramp_owed [$];
  plan_row_t plan [$];

  int  ticks_sent;
  int  checked;
  int  mismatches;
  int  cycle_count;
  int  advances_seen;
  int  top_stage_advances;
  int  long_holds;
  bit  quiet;
  bit  long_hold_req;

  three_phase_startup_ramp DUT (
    .clk               (clk),
    .rst_n             (rst_n),
    .cfg_we            (cfg_we),
    .cfg_index         (cfg_index),
    .cfg_data          (cfg_data),
    .in_valid          (in_valid),
    .in_stall          (in_stall),
    .in_enable         (in_enable),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_drive         (out_drive),
    .out_stage         (out_stage),
    .out_delay_us      (out_delay_us),
    .out_stage_changed (out_stage_changed)
  );

  always begin
    clk = 1'b0;
    #10;
    clk = 1'b1;
    #10;
  end

  // ---------------------------------------------------------------- predictor
  function automatic logic [DelayW-1:0] floored_sub(logic [DelayW-1:0] v,
                                                    logic [DelayW-1:0] d);
    return (d >= v) ? DelayW'(1) : v - d;
  endfunction

  function automatic logic [PeriodW-1:0] step_residue(logic [PeriodW-1:0] r,
                                                      logic [PeriodW-1:0] period,
                                                      output bit wrapped);
    int lim;
    int n;
    lim = (period == '0) ? 256 : int'(period);
    n = int'(r) + 1;
    wrapped = (n >= lim);
    return wrapped ? '0 : PeriodW'(n);
  endfunction

  // Advance the residues; on a due check, shorten the delay and bump the stage
  function automatic bit close_cycle();
    bit ew, lw, due;
    ramp_st.early_residue = step_residue(ramp_st.early_residue, ramp_cfg.early_period, ew);
    ramp_st.late_residue  = step_residue(ramp_st.late_residue, ramp_cfg.late_period, lw);
    due = (ramp_st.stage_count < ramp_cfg.early_stages) ? ew : lw;
    if (!due) return 1'b0;
    if (ramp_st.phase_delay > ramp_cfg.coarse_threshold)
      ramp_st.phase_delay = floored_sub(ramp_st.phase_delay, ramp_cfg.coarse_decrement);
    else if (ramp_st.phase_delay > ramp_cfg.fine_threshold)
      ramp_st.phase_delay = floored_sub(ramp_st.phase_delay, ramp_cfg.fine_decrement);
    else
      return 1'b0;
    if (ramp_st.stage_count != StageMax) ramp_st.stage_count++;
    return 1'b1;
  endfunction

  function automatic ramp_out_t ramp_tick(logic en);
    bit changed;
    ramp_out_t r;
    changed = 1'b0;
    if (en) begin
      if (ramp_st.countdown == '0) begin
        case (ramp_st.phase_index)
          PhaseCoil1: begin
            ramp_st.drive_lines = DriveCoil1;
            ramp_st.phase_index = PhaseCoil2;
          end
          PhaseCoil2: begin
            ramp_st.drive_lines = DriveCoil2;
            ramp_st.phase_index = PhaseCoil0;
            changed = close_cycle();
          end
          default: begin
            ramp_st.drive_lines = DriveCoil0;
            ramp_st.phase_index = PhaseCoil1;
          end
        endcase
        if (ramp_st.phase_delay == '0) ramp_st.phase_delay = DelayW'(1);
        ramp_st.countdown = ramp_st.phase_delay - DelayW'(1);
      end else begin
        ramp_st.countdown = ramp_st.countdown - DelayW'(1);
      end
    end
    r.drive    = ramp_st.drive_lines;
    r.stage    = ramp_st.stage_count;
    r.delay_us = ramp_st.phase_delay;
    r.changed  = changed;
    return r;
  endfunction

  function automatic void load_reg(logic [CfgIdxW-1:0] idx, logic [CfgDataW-1:0] data);
    case (idx)
      RegInitialDelay: begin
        ramp_st.phase_delay = (data == '0) ? DelayW'(1) : data;
      end
      RegCoarseThresh: ramp_cfg.coarse_threshold = data;
      RegCoarseDec:    ramp_cfg.coarse_decrement = data;
      RegFineThresh:   ramp_cfg.fine_threshold = data;
      RegFineDec:      ramp_cfg.fine_decrement = data;
      RegEarlyPeriod:  ramp_cfg.early_period = data[PeriodW-1:0];
      RegLatePeriod:   ramp_cfg.late_period = data[PeriodW-1:0];
      RegEarlyStages:  ramp_cfg.early_stages = data[StageW-1:0];
      default: ;
    endcase
  endfunction

  function automatic void reset_ramp();
    ramp_cfg.coarse_threshold = RstCoarseThresh;
    ramp_cfg.coarse_decrement = RstCoarseDec;
    ramp_cfg.fine_threshold   = RstFineThresh;
    ramp_cfg.fine_decrement   = RstFineDec;
    ramp_cfg.early_period     = RstEarlyPeriod;
    ramp_cfg.late_period      = RstLatePeriod;
    ramp_cfg.early_stages     = RstEarlyStages;
    ramp_st                   = '0;
    ramp_st.phase_delay       = RstInitialDelay;
  endfunction

  // ---------------------------------------------------------------- directed table
  function automatic plan_row_t tick_row(logic en);
    plan_row_t r;
    r.kind  = RowTick;
    r.idx   = '0;
    r.data  = '0;
    r.en    = en;
    r.typed = 1'b0;
    r.want  = '0;
    return r;
  endfunction

  function automatic plan_row_t typed_row(logic en, logic [2:0] drive, logic [StageW-1:0] stage,
                                          logic [DelayW-1:0] delay_us, logic changed);
    plan_row_t r;
    r = tick_row(en);
    r.typed = 1'b1;
    r.want  = '{drive, stage, delay_us, changed};
    return r;
  endfunction

  function automatic plan_row_t write_row(logic [CfgIdxW-1:0] idx, logic [CfgDataW-1:0] data);
    plan_row_t r;
    r = tick_row(1'b0);
    r.kind = RowWrite;
    r.idx  = idx;
    r.data = data;
    return r;
  endfunction

  function automatic void build_plan();
    // hold straight out of reset, then a zero initial delay taken as one
    plan.push_back(typed_row(1'b0, DriveOff, 8'd0, RstInitialDelay, 1'b0));
    plan.push_back(write_row(RegInitialDelay, 16'd0));
    plan.push_back(typed_row(1'b1, DriveCoil0, 8'd0, 16'd1, 1'b0));
    plan.push_back(typed_row(1'b1, DriveCoil1, 8'd0, 16'd1, 1'b0));
    plan.push_back(typed_row(1'b0, DriveCoil1, 8'd0, 16'd1, 1'b0));
    plan.push_back(typed_row(1'b1, DriveCoil2, 8'd0, 16'd1, 1'b0));
    // shrink the early period under its residue
    plan.push_back(write_row(RegEarlyPeriod, 16'd1));
    plan.push_back(typed_row(1'b1, DriveCoil0, 8'd0, 16'd1, 1'b0));
    plan.push_back(typed_row(1'b1, DriveCoil1, 8'd0, 16'd1, 1'b0));
    // widest delay hit by the widest coarse step: floors at one
    plan.push_back(write_row(RegInitialDelay, 16'hFFFF));
    plan.push_back(write_row(RegCoarseThresh, 16'd0));
    plan.push_back(write_row(RegCoarseDec, 16'hFFFF));
    plan.push_back(typed_row(1'b1, DriveCoil2, 8'd1, 16'd1, 1'b1));
    // unknown index must be ignored; then a fine-step ramp on the late period
    plan.push_back(write_row(RegSpare, 16'hFFFF));
    plan.push_back(write_row(RegCoarseThresh, 16'hFFFF));
    plan.push_back(write_row(RegFineThresh, 16'd0));
    plan.push_back(write_row(RegFineDec, 16'd2));
    plan.push_back(write_row(RegInitialDelay, 16'd2));
    plan.push_back(write_row(RegEarlyStages, 16'd0));
    plan.push_back(write_row(RegLatePeriod, 16'd1));
    for (int i = 0; i < 10; i++) plan.push_back(tick_row(i != 5));
  endfunction

  // ---------------------------------------------------------------- drivers
  task automatic write_reg(logic [CfgIdxW-1:0] idx, logic [CfgDataW-1:0] data);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    load_reg(idx, data);
    @(negedge clk);
    cfg_we <= 1'b0;
    @(negedge clk);
  endtask

  // Offer one tick, wait for its transfer, and log the predicted result
  task automatic send_tick(logic en, bit typed = 1'b0, ramp_out_t want = '0);
    ramp_out_t guess;
    if (!quiet && $urandom_range(0, 7) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 5)) @(negedge clk);
    end
    in_valid  <= 1'b1;
    in_enable <= en;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    guess = ramp_tick(en);
    ramp_owed.push_back(typed ? want : guess);
    ticks_sent++;
    @(negedge clk);
  endtask

  // Drop valid and let every owed result arrive before touching registers
  task automatic drain();
    in_valid <= 1'b0;
    while (ramp_owed.size() != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  function automatic logic [CfgDataW-1:0] pick_level();
    case ($urandom_range(0, 4))
      0:       return '0;
      1:       return CfgDataW'($urandom_range(0, 65535));
      default: return CfgDataW'($urandom_range(0, 20));
    endcase
  endfunction

  function automatic logic [CfgDataW-1:0] pick_step();
    case ($urandom_range(0, 5))
      0:       return '0;
      1:       return 16'hFFFF;
      2:       return CfgDataW'($urandom_range(0, 65535));
      default: return CfgDataW'($urandom_range(1, 6));
    endcase
  endfunction

  // Byte registers get junk in the upper byte now and then
  function automatic logic [CfgDataW-1:0] pick_byte();
    logic [7:0] v;
    case ($urandom_range(0, 5))
      0:       v = 8'd0;
      1:       v = 8'd255;
      2:       v = 8'($urandom_range(0, 255));
      default: v = 8'($urandom_range(1, 4));
    endcase
    return {8'($urandom_range(0, 1) ? $urandom_range(0, 255) : 0), v};
  endfunction

  task automatic pick_setting();
    write_reg(RegInitialDelay, ($urandom_range(0, 9) == 0) ?
              CfgDataW'($urandom_range(13, 40)) : CfgDataW'($urandom_range(0, 12)));
    write_reg(RegCoarseThresh, pick_level());
    write_reg(RegCoarseDec, pick_step());
    write_reg(RegFineThresh, pick_level());
    write_reg(RegFineDec, pick_step());
    write_reg(RegEarlyPeriod, pick_byte());
    write_reg(RegLatePeriod, pick_byte());
    write_reg(RegEarlyStages, pick_byte());
  endtask

  // ---------------------------------------------------------------- receiver
  initial begin
    out_stall = 1'b0;
    forever begin
      @(negedge clk);
      if (long_hold_req) begin
        // hold off long enough to back the block up into its input
        out_stall <= 1'b1;
        repeat (LongHold) @(negedge clk);
        out_stall <= 1'b0;
        long_hold_req = 1'b0;
        long_holds++;
      end else if (!quiet && $urandom_range(0, 5) == 0) begin
        out_stall <= 1'b1;
        repeat ($urandom_range(1, 5)) @(negedge clk);
        out_stall <= 1'b0;
      end
    end
  end

  // ---------------------------------------------------------------- checker
  function automatic void flag_result(string what, ramp_out_t want, ramp_out_t got);
    mismatches++;
    if (mismatches <= 10)
      $display("%s at result %0d: want %b/%0d/%0d/%b, got %b/%0d/%0d/%b",
               what, checked, want.drive, want.stage, want.delay_us, want.changed,
               got.drive, got.stage, got.delay_us, got.changed);
  endfunction

  always @(posedge clk) begin
    ramp_out_t got;
    ramp_out_t want;
    if (rst_n && out_valid && !out_stall) begin
      got = {out_drive, out_stage, out_delay_us, out_stage_changed};
      checked++;
      if (got.changed === 1'b1) begin
        advances_seen++;
        if (got.stage == StageMax) top_stage_advances++;
      end
      if (ramp_owed.size() == 0) begin
        flag_result("unexpected transfer", '0, got);
      end else begin
        want = ramp_owed.pop_front();
        if (got.drive !== want.drive || got.stage !== want.stage ||
            got.delay_us !== want.delay_us || got.changed !== want.changed)
          flag_result("mismatch", want, got);
      end
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CycleLimit) begin
      $display("timeout after %0d cycles, %0d results owed", cycle_count, ramp_owed.size());
      $display("end of test: mismatches");
      $finish;
    end
  end

  // ---------------------------------------------------------------- main sequence
  initial begin
    int span;
    int phase;
    in_valid  = 1'b0;
    in_enable = 1'b0;
    cfg_we    = 1'b0;
    cfg_index = '0;
    cfg_data  = '0;
    rst_n     = 1'b0;
    reset_ramp();
    build_plan();
    repeat (12) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // walk the directed table
    foreach (plan[i]) begin
      if (plan[i].kind == RowWrite) begin
        drain();
        write_reg(plan[i].idx, plan[i].data);
      end else begin
        send_tick(plan[i].en, plan[i].typed, plan[i].want);
      end
    end

    // random settings, each followed by a burst of mostly enabled ticks
    phase = 0;
    while (ticks_sent < RandomTicks) begin
      drain();
      pick_setting();
      if (phase == 1) long_hold_req = 1'b1;
      span = $urandom_range(40, 120);
      repeat (span) send_tick($urandom_range(0, 99) < 85);
      phase++;
    end

    // drive the stage into saturation with no idling on either side
    drain();
    quiet = 1'b1;
    write_reg(RegCoarseThresh, 16'hFFFF);
    write_reg(RegFineThresh, 16'd0);
    write_reg(RegFineDec, 16'd0);
    write_reg(RegInitialDelay, 16'd1);
    write_reg(RegEarlyPeriod, 16'd1);
    write_reg(RegLatePeriod, 16'd1);
    repeat (SatTicks) send_tick(1'b1);
    drain();

    $display("covered %0d ticks over %0d random settings, %0d results checked",
             ticks_sent, phase, checked);
    $display("%0d stage advances seen, %0d at the top stage, %0d long receiver holds",
             advances_seen, top_stage_advances, long_holds);
    if (mismatches == 0 && ramp_owed.size() == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule
